FILE: design/crcdfr_pkg.sv
// Package for the CRC-8 command packet deframer.
// Holds the controller/datapath interface types, status codes and the CRC fold.
// No dependencies.
`default_nettype none

package crcdfr_pkg;

  localparam int unsigned STORE_DEPTH = 32;
  localparam int unsigned IDX_W       = 5;

  // Result status codes.
  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_BAD_OPCODE  = 2'd1;
  localparam logic [1:0] STAT_BAD_LENGTH  = 2'd2;
  localparam logic [1:0] STAT_CRC_MISMATCH = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CRC_POLY = 2'd0;
  localparam logic [1:0] CFG_OP_MIN   = 2'd1;
  localparam logic [1:0] CFG_OP_MAX   = 2'd2;

  typedef enum logic [2:0] {
    EMIT_NONE   = 3'd0,
    EMIT_BADOP  = 3'd1,
    EMIT_BADLEN = 3'd2,
    EMIT_CRC    = 3'd3,
    EMIT_REP    = 3'd4
  } emit_sel_t;

  typedef struct packed {
    logic      take_op;
    logic      take_len;
    logic      take_data;
    logic      take_crc;
    logic      rd_wait;
    emit_sel_t emit_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic op_valid;
    logic len_bad;
    logic len_in_zero;
    logic held_len_zero;
    logic data_last;
    logic crc_ok;
    logic rep_last;
    logic out_free;
  } dp_stat_t;

  // One byte folded into a CRC-8, MSB first.
  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ poly) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/crc8_command_packet_deframer_top.sv
// An error or empty-frame beat sits in the output register the cycle after the byte that
// causes it; the first payload beat of a good frame follows the read state and then the
// output state. One byte per cycle is taken while the output register is free or being
// drained and no replay is in progress; a good frame replays each payload beat through the
// registered read port of the payload store. Config writes are always ready.
// Reset (rst_n low, synchronous) returns the parser to the opcode phase, empties the
// output register and restores the config defaults; the payload store is not cleared.
`default_nettype none

module crc8_command_packet_deframer_top
  import crcdfr_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_status,
  output logic [7:0]      out_frame_opcode,
  output logic [4:0]      out_frame_length,
  output logic            out_payload_valid,
  output logic [7:0]      out_payload_byte,
  output logic [4:0]      out_payload_index,
  output logic [7:0]      out_crc_received,
  output logic [7:0]      out_crc_computed,
  output logic            out_last,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  crcdfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  crcdfr_dp #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_rx_byte        (in_rx_byte),
    .cfg_we            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_frame_opcode  (out_frame_opcode),
    .out_frame_length  (out_frame_length),
    .out_payload_valid (out_payload_valid),
    .out_payload_byte  (out_payload_byte),
    .out_payload_index (out_payload_index),
    .out_crc_received  (out_crc_received),
    .out_crc_computed  (out_crc_computed),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire

FILE: design/crcdfr_ctrl.sv
// Frame parser controller for the CRC-8 command packet deframer.
// Depends on crcdfr_pkg; drives the datapath through dp_cmd_t.
`default_nettype none

module crcdfr_ctrl
  import crcdfr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [5:0] {
    ST_OPCODE = 6'b000001,
    ST_LENGTH = 6'b000010,
    ST_DATA   = 6'b000100,
    ST_CRC    = 6'b001000,
    ST_RD     = 6'b010000,
    ST_OUT    = 6'b100000
  } state_t;

  state_t st_r, st_nxt;
  logic   in_acc;

  // Every byte may cause a result, so bytes are only taken with the output slot free.
  assign in_ready = ((st_r == ST_OPCODE) || (st_r == ST_LENGTH) || (st_r == ST_DATA) ||
                     (st_r == ST_CRC)) && stat.out_free;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    st_nxt        = st_r;
    cmd.take_op   = 1'b0;
    cmd.take_len  = 1'b0;
    cmd.take_data = 1'b0;
    cmd.take_crc  = 1'b0;
    cmd.rd_wait   = 1'b0;
    cmd.emit_sel  = EMIT_NONE;
    case (st_r)
      ST_OPCODE: begin
        if (in_acc) begin
          cmd.take_op = 1'b1;
          if (stat.op_valid) st_nxt = ST_LENGTH;
          else cmd.emit_sel = EMIT_BADOP;
        end
      end
      ST_LENGTH: begin
        if (in_acc) begin
          if (stat.len_bad) begin
            cmd.emit_sel = EMIT_BADLEN;
            st_nxt       = ST_OPCODE;
          end else begin
            cmd.take_len = 1'b1;
            st_nxt       = stat.len_in_zero ? ST_CRC : ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (in_acc) begin
          cmd.take_data = 1'b1;
          if (stat.data_last) st_nxt = ST_CRC;
        end
      end
      ST_CRC: begin
        if (in_acc) begin
          cmd.take_crc = 1'b1;
          if (!stat.crc_ok || stat.held_len_zero) begin
            cmd.emit_sel = EMIT_CRC;
            st_nxt       = ST_OPCODE;
          end else begin
            st_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        cmd.rd_wait = 1'b1;
        st_nxt      = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.emit_sel = EMIT_REP;
          st_nxt       = stat.rep_last ? ST_OPCODE : ST_RD;
        end
      end
      default: st_nxt = ST_OPCODE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_OPCODE;
    else st_r <= st_nxt;
  end

  // The store read is registered, so a read state is always followed by the output state.
  a_rd_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RD) |=> (st_r == ST_OUT))
    else $error("replay read not followed by output state");

  // No byte is taken while a payload replay is in progress.
  a_no_take_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_RD) || (st_r == ST_OUT)) |-> !in_ready)
    else $error("input ready during replay");

endmodule

`default_nettype wire

FILE: design/crcdfr_dp.sv
// Datapath for the CRC-8 command packet deframer: config registers, frame
// fields, running CRC, payload store and the output register. Depends on crcdfr_pkg.
`default_nettype none

module crcdfr_dp
  import crcdfr_pkg::*;
#(
  parameter int unsigned BUF_DEPTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire dp_cmd_t    cmd,
  output dp_stat_t        stat,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_status,
  output logic [7:0]      out_frame_opcode,
  output logic [4:0]      out_frame_length,
  output logic            out_payload_valid,
  output logic [7:0]      out_payload_byte,
  output logic [4:0]      out_payload_index,
  output logic [7:0]      out_crc_received,
  output logic [7:0]      out_crc_computed,
  output logic            out_last
);

  localparam logic [8:0] LEN_LIMIT = 9'((BUF_DEPTH < STORE_DEPTH) ? BUF_DEPTH : STORE_DEPTH);

  logic [7:0]       poly_r, op_min_r, op_max_r;
  logic [7:0]       held_opcode_r;
  logic [IDX_W-1:0] held_length_r;
  logic [IDX_W-1:0] cnt_r;
  logic [IDX_W-1:0] rep_cnt_r;
  logic [7:0]       crc_r;
  logic [7:0]       crc_rx_r;
  logic [7:0]       mem [STORE_DEPTH];
  logic [7:0]       rd_data_r;

  logic             out_valid_r;
  logic [1:0]       status_r;
  logic [7:0]       opcode_r;
  logic [4:0]       length_r;
  logic             pv_r;
  logic [7:0]       pb_r;
  logic [4:0]       pi_r;
  logic [7:0]       crx_r;
  logic [7:0]       ccomp_r;
  logic             last_r;

  logic             load;
  logic [1:0]       e_status;
  logic [7:0]       e_opcode;
  logic [4:0]       e_length;
  logic             e_pv;
  logic [7:0]       e_pb;
  logic [4:0]       e_pi;
  logic [7:0]       e_crx;
  logic [7:0]       e_ccomp;
  logic             e_last;
  logic [IDX_W:0]   cnt_inc;
  logic [IDX_W:0]   rep_inc;

  assign cnt_inc = {1'b0, cnt_r} + 1'b1;
  assign rep_inc = {1'b0, rep_cnt_r} + 1'b1;

  always_comb begin
    stat.op_valid      = (in_rx_byte >= op_min_r) && (in_rx_byte <= op_max_r);
    stat.len_bad       = {1'b0, in_rx_byte} >= LEN_LIMIT;
    stat.len_in_zero   = (in_rx_byte == 8'd0);
    stat.held_len_zero = (held_length_r == '0);
    stat.data_last     = cnt_inc >= {1'b0, held_length_r};
    stat.crc_ok        = (in_rx_byte == crc_r);
    stat.rep_last      = rep_inc == {1'b0, held_length_r};
    stat.out_free      = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r   <= 8'd7;
      op_min_r <= 8'd0;
      op_max_r <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CRC_POLY: poly_r   <= cfg_data;
        CFG_OP_MIN:   op_min_r <= cfg_data;
        CFG_OP_MAX:   op_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_op) held_opcode_r <= in_rx_byte;
    if (cmd.take_len) begin
      held_length_r <= in_rx_byte[IDX_W-1:0];
      cnt_r         <= '0;
      rep_cnt_r     <= '0;
      crc_r         <= '0;
    end
    if (cmd.take_data) begin
      cnt_r <= cnt_inc[IDX_W-1:0];
      crc_r <= crc8_fold(crc_r, in_rx_byte, poly_r);
    end
    if (cmd.take_crc) crc_rx_r <= in_rx_byte;
    if (cmd.emit_sel == EMIT_REP) rep_cnt_r <= rep_inc[IDX_W-1:0];
  end

  // Payload store: one write port, one registered read port at the replay index.
  always_ff @(posedge clk) begin
    if (cmd.take_data) mem[cnt_r] <= in_rx_byte;
    if (cmd.rd_wait) rd_data_r <= mem[rep_cnt_r];
  end

  always_comb begin
    e_status = STAT_OK;
    e_opcode = held_opcode_r;
    e_length = '0;
    e_pv     = 1'b0;
    e_pb     = '0;
    e_pi     = '0;
    e_crx    = '0;
    e_ccomp  = '0;
    e_last   = 1'b1;
    case (cmd.emit_sel)
      EMIT_BADOP: begin
        e_status = STAT_BAD_OPCODE;
        e_opcode = in_rx_byte;
      end
      EMIT_BADLEN: e_status = STAT_BAD_LENGTH;
      EMIT_CRC: begin
        e_status = stat.crc_ok ? STAT_OK : STAT_CRC_MISMATCH;
        e_length = held_length_r;
        e_crx    = in_rx_byte;
        e_ccomp  = crc_r;
      end
      EMIT_REP: begin
        e_length = held_length_r;
        e_pv     = 1'b1;
        e_pb     = rd_data_r;
        e_pi     = rep_cnt_r;
        e_crx    = crc_rx_r;
        e_ccomp  = crc_r;
        e_last   = stat.rep_last;
      end
      default: e_last = 1'b0;
    endcase
  end

  assign load = (cmd.emit_sel != EMIT_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (load) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= e_status;
      opcode_r <= e_opcode;
      length_r <= e_length;
      pv_r     <= e_pv;
      pb_r     <= e_pb;
      pi_r     <= e_pi;
      crx_r    <= e_crx;
      ccomp_r  <= e_ccomp;
      last_r   <= e_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_frame_opcode  = opcode_r;
  assign out_frame_length  = length_r;
  assign out_payload_valid = pv_r;
  assign out_payload_byte  = pb_r;
  assign out_payload_index = pi_r;
  assign out_crc_received  = crx_r;
  assign out_crc_computed  = ccomp_r;
  assign out_last          = last_r;

  // A result is only loaded into a free output register.
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> stat.out_free)
    else $error("result loaded over a pending beat");

  // Replay never reads past the stored payload.
  a_rep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_sel == EMIT_REP) |-> (rep_cnt_r < held_length_r))
    else $error("replay index beyond frame length");

  // A fresh length always restarts the byte count.
  a_len_clears_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_len |=> (cnt_r == '0) && (crc_r == 8'd0))
    else $error("byte count or CRC not restarted");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for the CRC-8 command packet deframer (opcode, length, payload, CRC).
// A scoreboard class predicts every result beat from the accepted bytes; plain tasks drive
// the byte and register channels. Depends on crcdfr_pkg and the deframer top level.
`default_nettype none

typedef enum logic [1:0] {
  PH_OPCODE = 2'd0,
  PH_LENGTH = 2'd1,
  PH_DATA   = 2'd2,
  PH_CRC    = 2'd3
} parse_phase_t;

typedef struct packed {
  logic [1:0] status;
  logic [7:0] opcode;
  logic [4:0] length;
  logic       pay_valid;
  logic [7:0] pay_byte;
  logic [4:0] pay_index;
  logic [7:0] crc_rx;
  logic [7:0] crc_calc;
  logic       last;
} deframe_beat_t;

module tb_top
  import crcdfr_pkg::*;
();

  localparam int unsigned BUF_DEPTH = 32;
  localparam int unsigned LEN_LIMIT = (BUF_DEPTH < 32) ? BUF_DEPTH : 32;

  class frame_checker;
    logic [7:0]    poly;
    logic [7:0]    op_lo;
    logic [7:0]    op_hi;
    parse_phase_t  phase;
    logic [7:0]    cur_op;
    logic [4:0]    cur_len;
    logic [4:0]    got_cnt;
    logic [7:0]    crc;
    logic [7:0]    store [32];
    deframe_beat_t pending [$];
    int            fails;
    int            made;

    function new();
      poly    = 8'h07;
      op_lo   = 8'h00;
      op_hi   = 8'hFF;
      phase   = PH_OPCODE;
      cur_op  = '0;
      cur_len = '0;
      got_cnt = '0;
      crc     = '0;
      fails   = 0;
      made    = 0;
    endfunction

    function logic [7:0] fold(input logic [7:0] c_in, input logic [7:0] b);
      logic [7:0] c;
      c = c_in ^ b;
      for (int i = 0; i < 8; i++) begin
        if (c[7]) c = {c[6:0], 1'b0} ^ poly;
        else c = {c[6:0], 1'b0};
      end
      return c;
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [7:0] v);
      case (idx)
        CFG_CRC_POLY: poly = v;
        CFG_OP_MIN: op_lo = v;
        CFG_OP_MAX: op_hi = v;
        default: ;
      endcase
    endfunction

    function void push(input logic [1:0] st, input logic [7:0] op, input logic [4:0] len,
                       input logic pv, input logic [7:0] pb, input logic [4:0] pi,
                       input logic [7:0] crx, input logic [7:0] cc, input logic lst);
      deframe_beat_t e;
      e = '{st, op, len, pv, pb, pi, crx, cc, lst};
      pending.push_back(e);
      made++;
    endfunction

    function bit in_frame();
      return phase != PH_OPCODE;
    endfunction

    function bit wants_length();
      return phase == PH_LENGTH;
    endfunction

    // Advances the parser copy by one accepted byte and queues what it causes.
    function void note_byte(input logic [7:0] b);
      case (phase)
        PH_OPCODE: begin
          cur_op = b;
          if (b < op_lo || b > op_hi) begin
            push(STAT_BAD_OPCODE, b, '0, 1'b0, '0, '0, '0, '0, 1'b1);
          end else begin
            crc     = '0;
            got_cnt = '0;
            cur_len = '0;
            phase   = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          if (b >= LEN_LIMIT) begin
            push(STAT_BAD_LENGTH, cur_op, '0, 1'b0, '0, '0, '0, '0, 1'b1);
            phase = PH_OPCODE;
          end else begin
            cur_len = b[4:0];
            got_cnt = '0;
            crc     = '0;
            phase   = (b == 0) ? PH_CRC : PH_DATA;
          end
        end
        PH_DATA: begin
          store[got_cnt] = b;
          crc     = fold(crc, b);
          got_cnt = got_cnt + 5'd1;
          if (got_cnt >= cur_len) phase = PH_CRC;
        end
        default: begin
          phase = PH_OPCODE;
          if (b != crc) begin
            push(STAT_CRC_MISMATCH, cur_op, cur_len, 1'b0, '0, '0, b, crc, 1'b1);
          end else if (cur_len == 0) begin
            push(STAT_OK, cur_op, '0, 1'b0, '0, '0, b, crc, 1'b1);
          end else begin
            for (int i = 0; i < cur_len; i++)
              push(STAT_OK, cur_op, cur_len, 1'b1, store[i], 5'(i), b, crc,
                   (i == cur_len - 1));
          end
        end
      endcase
    endfunction

    task report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fails++;
    endtask

    task cmp(input string name, input logic [7:0] g, input logic [7:0] e);
      if (g !== e) report($sformatf("%s got %0h expected %0h", name, g, e));
    endtask

    task check_beat(input deframe_beat_t got);
      deframe_beat_t e;
      if (pending.size() == 0) begin
        report($sformatf("result beat with nothing expected, status %0d", got.status));
      end else begin
        e = pending.pop_front();
        cmp("status", 8'(got.status), 8'(e.status));
        cmp("frame_opcode", got.opcode, e.opcode);
        cmp("frame_length", 8'(got.length), 8'(e.length));
        cmp("payload_valid", 8'(got.pay_valid), 8'(e.pay_valid));
        cmp("payload_byte", got.pay_byte, e.pay_byte);
        cmp("payload_index", 8'(got.pay_index), 8'(e.pay_index));
        cmp("crc_received", got.crc_rx, e.crc_rx);
        cmp("crc_computed", got.crc_calc, e.crc_calc);
        cmp("last", 8'(got.last), 8'(e.last));
      end
    endtask

    task finish_up();
      if (pending.size() != 0)
        report($sformatf("%0d result beats never arrived", pending.size()));
    endtask
  endclass

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_status;
  logic [7:0] out_frame_opcode;
  logic [4:0] out_frame_length;
  logic       out_payload_valid;
  logic [7:0] out_payload_byte;
  logic [4:0] out_payload_index;
  logic [7:0] out_crc_received;
  logic [7:0] out_crc_computed;
  logic       out_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = CFG_CRC_POLY;
  logic [7:0] cfg_data = 8'h00;

  frame_checker chk;
  bit           calm = 1'b0;
  int           n_sent = 0;

  crc8_command_packet_deframer_top #(.BUF_DEPTH(BUF_DEPTH)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_frame_opcode(out_frame_opcode),
    .out_frame_length(out_frame_length), .out_payload_valid(out_payload_valid),
    .out_payload_byte(out_payload_byte), .out_payload_index(out_payload_index),
    .out_crc_received(out_crc_received), .out_crc_computed(out_crc_computed),
    .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Mostly short gaps, a few long ones, none at all while calm is set.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  initial begin
    int run;
    int gap;
    forever begin
      out_ready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    deframe_beat_t got;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_status, out_frame_opcode, out_frame_length, out_payload_valid,
              out_payload_byte, out_payload_index, out_crc_received, out_crc_computed,
              out_last};
      chk.check_beat(got);
    end
  end

  // Leaves in_valid high after the beat is taken; the next call or drain decides.
  task send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    chk.note_byte(b);
    n_sent++;
  endtask

  task drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (chk.pending.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  task program_regs(input logic [7:0] poly, input logic [7:0] lo, input logic [7:0] hi);
    logic [1:0] idx [3];
    logic [7:0] val [3];
    idx = '{CFG_CRC_POLY, CFG_OP_MIN, CFG_OP_MAX};
    val = '{poly, lo, hi};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      chk.write_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Sends one frame; stops early where the parser rejects the opcode or the length.
  task send_frame(input logic [7:0] op, input logic [7:0] len_byte, input bit spoil_crc);
    logic [7:0] crc;
    logic [7:0] d;
    crc = '0;
    send_byte(op);
    if (!chk.wants_length()) return;
    send_byte(len_byte);
    if (!chk.in_frame()) return;
    for (int i = 0; i < len_byte; i++) begin
      case ($urandom_range(0, 7))
        0: d = 8'h00;
        1: d = 8'hFF;
        default: d = 8'($urandom);
      endcase
      crc = chk.fold(crc, d);
      send_byte(d);
    end
    send_byte(spoil_crc ? crc ^ 8'($urandom_range(1, 255)) : crc);
  endtask

  function automatic logic [7:0] pick_opcode();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return chk.op_lo;
    if (r == 1) return chk.op_hi;
    return 8'($urandom_range(chk.op_lo, chk.op_hi));
  endfunction

  initial begin
    logic [7:0] crc;
    logic [7:0] d;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] len;
    int         sel;
    int         budget;
    int         start;
    int         r;
    bit         first_long;

    chk = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset settings.
    send_frame(8'h00, 8'd0, 1'b0);
    send_frame(8'hFF, 8'd2, 1'b0);
    send_frame(8'h33, 8'd32, 1'b0);
    send_frame(8'h35, 8'd1, 1'b1);
    send_byte(8'h36);
    send_byte(8'h00);
    send_byte(8'h01);
    drain();

    // Narrow opcode window with a zero polynomial.
    program_regs(8'h00, 8'h10, 8'h20);
    send_byte(8'h0F);
    send_byte(8'h21);
    send_frame(8'h10, 8'd1, 1'b0);
    send_frame(8'h20, 8'd0, 1'b0);
    drain();

    // An empty window rejects every opcode.
    program_regs(8'hFF, 8'h80, 8'h7F);
    send_byte(8'h80);
    send_byte(8'h7F);
    drain();

    // The polynomial changes between two payload bytes of the same frame.
    program_regs(8'hFF, 8'h00, 8'hFF);
    send_byte(8'h40);
    send_byte(8'd2);
    d = 8'($urandom);
    crc = chk.fold(8'h00, d);
    send_byte(d);
    drain();
    program_regs(8'h31, 8'h00, 8'hFF);
    d = 8'($urandom);
    crc = chk.fold(crc, d);
    send_byte(d);
    send_byte(crc);
    drain();

    // Random part: rotate through register settings, mostly well-formed frames.
    first_long = 1'b1;
    sel = 0;
    start = n_sent;
    while (n_sent - start < 120 || chk.made < 48) begin
      case (sel % 6)
        0: program_regs(8'h07, 8'h00, 8'hFF);
        1: program_regs(8'h00, 8'($urandom_range(0, 100)), 8'($urandom_range(150, 255)));
        2: program_regs(8'hFF, 8'h00, 8'hFF);
        3: begin
          lo = 8'($urandom);
          program_regs(8'($urandom), lo, lo);
        end
        4: begin
          lo = 8'($urandom_range(1, 255));
          program_regs(8'($urandom), lo, 8'($urandom_range(0, lo - 1)));
        end
        default: begin
          lo = 8'($urandom);
          hi = 8'($urandom_range(lo, 255));
          program_regs(8'($urandom), lo, hi);
        end
      endcase
      budget = n_sent + ((sel % 6 == 4) ? 8 : 20);
      while (n_sent < budget) begin
        calm = ($urandom_range(0, 4) == 0);
        if (chk.op_lo > chk.op_hi) begin
          send_byte(8'($urandom));
        end else begin
          if (first_long) len = 8'd31;
          else if ($urandom_range(0, 9) == 0) len = 8'($urandom_range(6, 31));
          else len = 8'($urandom_range(0, 5));
          first_long = 1'b0;
          r = $urandom_range(0, 99);
          if (r < 70) begin
            send_frame(pick_opcode(), len, 1'b0);
          end else if (r < 78) begin
            send_frame(pick_opcode(), len, 1'b1);
          end else if (r < 85) begin
            send_frame(pick_opcode(), 8'($urandom_range(LEN_LIMIT, 255)), 1'b0);
          end else if (r < 92 && chk.op_lo > 8'h00) begin
            send_byte(8'($urandom_range(0, chk.op_lo - 1)));
          end else if (r < 92 && chk.op_hi < 8'hFF) begin
            send_byte(8'($urandom_range(chk.op_hi + 1, 255)));
          end else begin
            // Noise, then random bytes until the parser is back at an opcode.
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            while (chk.in_frame()) send_byte(8'($urandom));
          end
        end
      end
      calm = 1'b0;
      drain();
      sel++;
    end

    drain();
    repeat (20) @(posedge clk);
    chk.finish_up();
    if (chk.fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
